// File: rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor control unit.
// No dependencies; every other file in rtl/ imports this package.
package tcc_pkg;

    // Screen geometry in character cells.
    localparam int TEXT_COLS  = 80;
    localparam int TEXT_LINES = 30;

    localparam int COL_W  = 7;
    localparam int LINE_W = 5;
    localparam int CHAR_W = 8;
    localparam int ACT_W  = 2;

    localparam int TAB_STOP = 8;

    // Depth of the queue between classifier and executor (a power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Control codes.
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    // Cell action codes.
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 2'd0,
        ACT_ERASE      = 2'd1,
        ACT_DRAW       = 2'd2,
        ACT_OVERSTRIKE = 2'd3
    } cell_act_t;

    // Operation class assigned by the front end.
    typedef enum logic [2:0] {
        OP_PRINT,
        OP_TAB,
        OP_NL,
        OP_CR,
        OP_BS,
        OP_DEL,
        OP_FF
    } op_t;

    // One queued request.
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
    } req_t;

    // One finished result.
    typedef struct packed {
        logic [CHAR_W-1:0] echo_byte;
        cell_act_t         cell_action;
        logic [COL_W-1:0]  cell_col;
        logic [LINE_W-1:0] cell_line;
        logic [CHAR_W-1:0] glyph_code;
        logic              scroll_up;
        logic              clear_bottom;
        logic              clear_screen;
        logic [COL_W-1:0]  cursor_col;
        logic [LINE_W-1:0] cursor_line;
    } result_t;

endpackage

// File: rtl/tcc_front.sv
// Front end: classifies an incoming character byte into an operation.
// Depends on tcc_pkg.
module tcc_front (
    input  logic [7:0]     char_code,
    output tcc_pkg::req_t  req
);
    import tcc_pkg::*;

    always_comb
    begin
        req.char_code = char_code;
        case (char_code)
            CH_TAB:  req.op = OP_TAB;
            CH_NL:   req.op = OP_NL;
            CH_CR:   req.op = OP_CR;
            CH_BS:   req.op = OP_BS;
            CH_DEL:  req.op = OP_DEL;
            CH_FF:   req.op = OP_FF;
            default: req.op = OP_PRINT;
        endcase
    end

endmodule

// File: rtl/tcc_queue.sv
// Short request queue between the classifier and the executor.
// Depends on tcc_pkg.
module tcc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tcc_pkg::req_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output tcc_pkg::req_t  rd_data,
    output logic           not_empty
);
    import tcc_pkg::*;

    req_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/tcc_back.sv
// Back end: keeps the cursor state, holds the result in an output register
// and executes one request per cycle unless it is stalled. Depends on tcc_pkg.
module tcc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  tcc_pkg::req_t    req,
    output logic             req_take,
    output logic             res_valid,
    output tcc_pkg::result_t res,
    input  logic             res_take
);
    import tcc_pkg::*;

    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(TEXT_COLS - 1);
    localparam logic [LINE_W:0]   SCROLL_LINE = (LINE_W + 1)'(TEXT_LINES - 1);
    localparam logic [LINE_W-1:0] KEEP_LINE   = LINE_W'(TEXT_LINES - 2);
    localparam logic [COL_W:0]    COLS_WIDE   = (COL_W + 1)'(TEXT_COLS);
    localparam logic [COL_W:0]    TAB_MASK    = ~((COL_W + 1)'(TAB_STOP - 1));
    localparam logic [COL_W:0]    TAB_INC     = (COL_W + 1)'(TAB_STOP);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [CHAR_W-1:0] last_reg, last_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg;
    result_t           out_reg, out_next;

    logic [COL_W:0]    col_inc, tab_col;
    logic [LINE_W:0]   line_inc;
    logic              wraps_down;
    logic [COL_W-1:0]  back_col;
    logic [LINE_W-1:0] back_line, down_line;

    assign req_take  = req_valid && (!out_valid_reg || res_take);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Shared cursor arithmetic.
    always_comb
    begin
        col_inc    = {1'b0, col_reg} + 1'b1;
        tab_col    = ({1'b0, col_reg} & TAB_MASK) + TAB_INC;
        line_inc   = {1'b0, line_reg} + 1'b1;
        wraps_down = (line_inc >= SCROLL_LINE);
        down_line  = wraps_down ? KEEP_LINE : line_inc[LINE_W-1:0];
        back_col   = col_reg;
        back_line  = line_reg;
        if (col_reg != '0)
        begin
            back_col = col_reg - 1'b1;
        end
        else if (line_reg != '0)
        begin
            back_col  = LAST_COL;
            back_line = line_reg - 1'b1;
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        last_next = last_reg;
        pend_next = 1'b0;

        out_next              = '0;
        out_next.echo_byte    = req.char_code;
        out_next.cell_action  = ACT_NONE;

        case (req.op)
            OP_TAB:
            begin
                if (tab_col >= COLS_WIDE)
                begin
                    col_next           = '0;
                    line_next          = down_line;
                    out_next.scroll_up = wraps_down;
                end
                else
                begin
                    col_next = tab_col[COL_W-1:0];
                end
            end
            OP_NL:
            begin
                col_next           = '0;
                line_next          = down_line;
                out_next.scroll_up = wraps_down;
            end
            OP_CR:
            begin
                col_next = '0;
            end
            OP_BS:
            begin
                col_next  = back_col;
                line_next = back_line;
                pend_next = 1'b1;
            end
            OP_DEL:
            begin
                col_next             = back_col;
                line_next            = back_line;
                out_next.cell_action = ACT_ERASE;
                out_next.cell_col    = back_col;
                out_next.cell_line   = back_line;
            end
            OP_FF:
            begin
                col_next              = '0;
                line_next             = '0;
                out_next.clear_screen = 1'b1;
            end
            default:
            begin
                // Printable: overstrike when it retypes the backspaced glyph.
                out_next.cell_action = (pend_reg && req.char_code == last_reg)
                                       ? ACT_OVERSTRIKE : ACT_DRAW;
                out_next.cell_col    = col_reg;
                out_next.cell_line   = line_reg;
                out_next.glyph_code  = req.char_code;
                last_next            = req.char_code;
                if (col_inc >= COLS_WIDE)
                begin
                    col_next              = '0;
                    line_next             = down_line;
                    out_next.scroll_up    = wraps_down;
                    out_next.clear_bottom = wraps_down;
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        endcase

        out_next.cursor_col  = col_next;
        out_next.cursor_line = line_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            line_reg      <= '0;
            last_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
            begin
                col_reg  <= col_next;
                line_reg <= line_next;
                last_reg <= last_next;
                pend_reg <= pend_next;
            end
            if (req_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/text_console_cursor_control_unit.sv
// Top level of the text console cursor control unit.
// Depends on tcc_pkg, tcc_front, tcc_queue and tcc_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   input    | push / full           | char_code
//   result   | empty / pop           | echo_byte, cell_action, cell_col,
//            |                       | cell_line, glyph_code, scroll_up,
//            |                       | clear_bottom, clear_screen,
//            |                       | cursor_col, cursor_line
//
// Sustained rate is one request per cycle unless results stall; the executor's
// cursor update is a combinational compare-and-increment. A request accepted
// into an empty unit passes the queue write, then the executor's output
// register, before it shows on the result ports. Reset clears the queue, the
// cursor, the last glyph and the pending flag. A stalled result holds in the
// output register while up to four more requests collect; full rises only then.
module text_console_cursor_control_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [tcc_pkg::CHAR_W-1:0]   char_code,
    output logic                         empty,
    input  logic                         pop,
    output logic [tcc_pkg::CHAR_W-1:0]   echo_byte,
    output logic [tcc_pkg::ACT_W-1:0]    cell_action,
    output logic [tcc_pkg::COL_W-1:0]    cell_col,
    output logic [tcc_pkg::LINE_W-1:0]   cell_line,
    output logic [tcc_pkg::CHAR_W-1:0]   glyph_code,
    output logic                         scroll_up,
    output logic                         clear_bottom,
    output logic                         clear_screen,
    output logic [tcc_pkg::COL_W-1:0]    cursor_col,
    output logic [tcc_pkg::LINE_W-1:0]   cursor_line
);
    import tcc_pkg::*;

    req_t    class_req;
    req_t    queue_head;
    logic    queue_not_empty;
    logic    queue_take;
    logic    res_valid;
    result_t res;

    // Classify the byte on the way in.
    tcc_front u_front (
        .char_code (char_code),
        .req       (class_req)
    );

    // Buffer classified requests so each side stalls on its own.
    tcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_data   (class_req),
        .full      (full),
        .rd_en     (queue_take),
        .rd_data   (queue_head),
        .not_empty (queue_not_empty)
    );

    // Execute against the cursor state and hold the result.
    tcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (queue_not_empty),
        .req       (queue_head),
        .req_take  (queue_take),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (pop)
    );

    // Drive the result ports from the output register.
    assign empty        = !res_valid;
    assign echo_byte    = res.echo_byte;
    assign cell_action  = res.cell_action;
    assign cell_col     = res.cell_col;
    assign cell_line    = res.cell_line;
    assign glyph_code   = res.glyph_code;
    assign scroll_up    = res.scroll_up;
    assign clear_bottom = res.clear_bottom;
    assign clear_screen = res.clear_screen;
    assign cursor_col   = res.cursor_col;
    assign cursor_line  = res.cursor_line;

endmodule
